// ===== design/tbt_pkg.sv =====
// Shared types, codes and constants for the thermistor Beta temperature block.
// No dependencies; every other design file refers to this package by scoped name.
`default_nettype none
package tbt_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HIGH  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_CLAMP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SERIES  = 2'd0,
    CFG_NOMINAL = 2'd1,
    CFG_BETA    = 2'd2,
    CFG_SUPPLY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } side_t;

  localparam int MANT_W = 32;
  localparam int OPND_W = 40;
  localparam int KINT_W = 6;
  localparam int MAG_W  = 23;
  localparam int DIV_W  = 39;
  localparam int X_W    = 53;
  localparam int Q_W    = 17;

  // 29815 * ln2 in Q16, rounded from ln2 in Q32.
  localparam logic [31:0] KQ16 = 32'((64'd29815 * 64'd2977044472 + 64'd32768) >> 16);
  localparam logic [6:0]  BETA_SCALE    = 7'd100;
  localparam logic [21:0] BETA_T0_SCALE = 22'd2981500;
  localparam logic [17:0] ZERO_C_CENTI  = 18'd27315;
  localparam logic [16:0] TK_MAX        = 17'd60082;
  localparam logic [15:0] TEMP_MIN      = 16'h8000;
  localparam logic [15:0] TEMP_MAX      = 16'h7FFF;

  function automatic logic [5:0] msb_index(input logic [OPND_W-1:0] x);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < OPND_W; i++) begin
      if (x[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== design/tbt_log_cell.sv =====
// One fraction bit of the base-2 logarithm for both operands, by squaring.
// Depends on tbt_pkg.
`default_nettype none
module tbt_log_cell #(
  parameter int FB  = 24,
  parameter int BIT = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tbt_pkg::side_t                side_i,
  input  wire logic [tbt_pkg::MANT_W-1:0]    mn_i,
  input  wire logic [tbt_pkg::MANT_W-1:0]    md_i,
  input  wire logic [tbt_pkg::KINT_W+FB-1:0] rn_i,
  input  wire logic [tbt_pkg::KINT_W+FB-1:0] rd_i,
  output tbt_pkg::side_t                     side_o,
  output logic [tbt_pkg::MANT_W-1:0]         mn_o,
  output logic [tbt_pkg::MANT_W-1:0]         md_o,
  output logic [tbt_pkg::KINT_W+FB-1:0]      rn_o,
  output logic [tbt_pkg::KINT_W+FB-1:0]      rd_o
);
  logic [2*tbt_pkg::MANT_W-1:0] pn, pd;
  logic [tbt_pkg::MANT_W:0]     sn, sd;
  tbt_pkg::side_t               side_r;
  logic [tbt_pkg::MANT_W-1:0]   mn_r, md_r, mn_nxt, md_nxt;
  logic [tbt_pkg::KINT_W+FB-1:0] rn_r, rd_r, rn_nxt, rd_nxt;

  always_comb begin
    pn = mn_i * mn_i;
    pd = md_i * md_i;
    sn = pn[2*tbt_pkg::MANT_W-1:tbt_pkg::MANT_W-1];
    sd = pd[2*tbt_pkg::MANT_W-1:tbt_pkg::MANT_W-1];
    rn_nxt = rn_i;
    rd_nxt = rd_i;
    // A square of two or more halves the mantissa and sets this bit.
    if (sn[tbt_pkg::MANT_W]) begin
      mn_nxt = sn[tbt_pkg::MANT_W:1];
      rn_nxt[BIT] = 1'b1;
    end else begin
      mn_nxt = sn[tbt_pkg::MANT_W-1:0];
    end
    if (sd[tbt_pkg::MANT_W]) begin
      md_nxt = sd[tbt_pkg::MANT_W:1];
      rd_nxt[BIT] = 1'b1;
    end else begin
      md_nxt = sd[tbt_pkg::MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= side_i;
    end
    mn_r <= mn_nxt;
    md_r <= md_nxt;
    rn_r <= rn_nxt;
    rd_r <= rd_nxt;
  end

  assign side_o = side_r;
  assign mn_o   = mn_r;
  assign md_o   = md_r;
  assign rn_o   = rn_r;
  assign rd_o   = rd_r;
endmodule
`default_nettype wire

// ===== design/tbt_div_cell.sv =====
// One quotient bit of the restoring division that yields the temperature.
// Depends on tbt_pkg.
`default_nettype none
module tbt_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tbt_pkg::side_t              side_i,
  input  wire logic [tbt_pkg::DIV_W-1:0]   rem_i,
  input  wire logic [tbt_pkg::DIV_W-1:0]   d_i,
  input  wire logic [tbt_pkg::Q_W-1:0]     xlo_i,
  input  wire logic [tbt_pkg::Q_W-1:0]     q_i,
  output tbt_pkg::side_t                   side_o,
  output logic [tbt_pkg::DIV_W-1:0]        rem_o,
  output logic [tbt_pkg::DIV_W-1:0]        d_o,
  output logic [tbt_pkg::Q_W-1:0]          xlo_o,
  output logic [tbt_pkg::Q_W-1:0]          q_o
);
  logic [tbt_pkg::DIV_W:0]   t;
  logic                      ge;
  tbt_pkg::side_t            side_r;
  logic [tbt_pkg::DIV_W-1:0] rem_r, rem_nxt, d_r;
  logic [tbt_pkg::Q_W-1:0]   xlo_r, q_r, q_nxt;

  always_comb begin
    t       = {rem_i, xlo_i[BIT]};
    ge      = t >= {1'b0, d_i};
    rem_nxt = ge ? tbt_pkg::DIV_W'(t - {1'b0, d_i}) : t[tbt_pkg::DIV_W-1:0];
    q_nxt   = q_i;
    q_nxt[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= side_i;
    end
    rem_r <= rem_nxt;
    d_r   <= d_i;
    xlo_r <= xlo_i;
    q_r   <= q_nxt;
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign d_o    = d_r;
  assign xlo_o  = xlo_r;
  assign q_o    = q_r;
endmodule
`default_nettype wire

// ===== design/thermistor_beta_temperature.sv =====
// Top level of the NTC thermistor Beta-equation temperature pipeline.
// Depends on tbt_pkg, tbt_log_cell and tbt_div_cell.
//
// Usage. A divider voltage in millivolts is offered on in_voltage_mv with
// start high; it is taken at any rising edge where busy is low. busy is high
// only while reset is held and for the cycle after, so a new item may be
// offered in every cycle. Each item yields exactly one result on
// out_temperature_centi (signed hundredths of a degree Celsius) and
// out_status, marked by out_valid for a single cycle; the receiver cannot
// stall, so results simply leave in the order items entered.
// The two chains of cells are one squaring cell per fraction bit of the
// logarithm and one restoring-division cell per quotient bit. Throughput is
// one item per cycle. The configuration registers (series and nominal
// resistance, Beta, supply) are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no item is in flight, as the block
// does not enforce this. Synchronous reset empties the pipeline and restores
// the register defaults; no result is produced for items lost to reset.
`default_nettype none
module thermistor_beta_temperature #(
  parameter int FRACTION_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] in_voltage_mv,
  output logic             out_valid,
  output logic signed [15:0] out_temperature_centi,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);
  localparam int FB  = FRACTION_BITS;
  localparam int LW  = tbt_pkg::KINT_W + FB;
  localparam int SH  = FB - 16;
  localparam logic [LW:0] RND = (SH > 0) ? (LW+1)'(1) << (SH - 1) : '0;
  localparam int QW  = tbt_pkg::Q_W;
  localparam int DW  = tbt_pkg::DIV_W;

  // Configuration registers.
  logic [19:0] series_r, nominal_r;
  logic [13:0] beta_r;
  logic [12:0] supply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r  <= 20'd10000;
      nominal_r <= 20'd10000;
      beta_r    <= 14'd3950;
      supply_r  <= 13'd3300;
    end else if (cfg_we) begin
      case (tbt_pkg::cfg_idx_t'(cfg_index))
        tbt_pkg::CFG_SERIES:  series_r  <= cfg_wdata;
        tbt_pkg::CFG_NOMINAL: nominal_r <= cfg_wdata;
        tbt_pkg::CFG_BETA:    beta_r    <= cfg_wdata[13:0];
        tbt_pkg::CFG_SUPPLY:  supply_r  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  logic busy_r;
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end
  assign busy = busy_r;

  wire logic accept = start && !busy;

  // Stage 1: classify the voltage and form the two products.
  tbt_pkg::side_t s1_side_r, s1_side_nxt;
  logic [tbt_pkg::OPND_W-1:0] s1_num_r, s1_den_r;
  logic [12:0] diff_mv;

  always_comb begin
    diff_mv = supply_r - {1'b0, in_voltage_mv};
    s1_side_nxt.valid  = accept;
    s1_side_nxt.status = tbt_pkg::ST_OK;
    if ({1'b0, in_voltage_mv} >= supply_r || nominal_r == '0) begin
      s1_side_nxt.status = tbt_pkg::ST_HIGH;
    end else if (in_voltage_mv == '0 || series_r == '0) begin
      s1_side_nxt.status = tbt_pkg::ST_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
    end else begin
      s1_side_r <= s1_side_nxt;
    end
    s1_num_r <= tbt_pkg::OPND_W'(series_r) * tbt_pkg::OPND_W'(in_voltage_mv);
    s1_den_r <= tbt_pkg::OPND_W'(nominal_r) * tbt_pkg::OPND_W'(diff_mv);
  end

  // Stage 2: normalise each operand to a Q31 mantissa and its integer log.
  tbt_pkg::side_t s2_side_r;
  logic [tbt_pkg::MANT_W-1:0] s2_mn_r, s2_md_r;
  logic [LW-1:0] s2_rn_r, s2_rd_r;
  logic [5:0] kn, kd;
  logic [tbt_pkg::OPND_W+30:0] shn, shd;

  always_comb begin
    kn  = tbt_pkg::msb_index(s1_num_r);
    kd  = tbt_pkg::msb_index(s1_den_r);
    shn = ({31'b0, s1_num_r} << 31) >> kn;
    shd = ({31'b0, s1_den_r} << 31) >> kd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else begin
      s2_side_r <= s1_side_r;
    end
    s2_mn_r <= shn[tbt_pkg::MANT_W-1:0];
    s2_md_r <= shd[tbt_pkg::MANT_W-1:0];
    s2_rn_r <= {kn, {FB{1'b0}}};
    s2_rd_r <= {kd, {FB{1'b0}}};
  end

  // Logarithm chain: cell j resolves fraction bit FB-1-j.
  tbt_pkg::side_t lside [0:FB];
  logic [tbt_pkg::MANT_W-1:0] lmn [0:FB];
  logic [tbt_pkg::MANT_W-1:0] lmd [0:FB];
  logic [LW-1:0] lrn [0:FB];
  logic [LW-1:0] lrd [0:FB];

  assign lside[0] = s2_side_r;
  assign lmn[0]   = s2_mn_r;
  assign lmd[0]   = s2_md_r;
  assign lrn[0]   = s2_rn_r;
  assign lrd[0]   = s2_rd_r;

  for (genvar j = 0; j < FB; j++) begin : g_log
    tbt_log_cell #(.FB(FB), .BIT(FB - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (lside[j]),
      .mn_i   (lmn[j]),
      .md_i   (lmd[j]),
      .rn_i   (lrn[j]),
      .rd_i   (lrd[j]),
      .side_o (lside[j+1]),
      .mn_o   (lmn[j+1]),
      .md_o   (lmd[j+1]),
      .rn_o   (lrn[j+1]),
      .rd_o   (lrd[j+1])
    );
  end

  // Stage 3: log difference, rounded half up in magnitude to Q16.
  tbt_pkg::side_t s3_side_r;
  logic s3_neg_r;
  logic [tbt_pkg::MAG_W-1:0] s3_mag_r;
  logic l_neg;
  logic [LW-1:0] l_diff;
  logic [LW:0] l_sum;

  always_comb begin
    l_neg  = lrn[FB] < lrd[FB];
    l_diff = l_neg ? lrd[FB] - lrn[FB] : lrn[FB] - lrd[FB];
    l_sum  = {1'b0, l_diff} + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r <= '0;
    end else begin
      s3_side_r <= lside[FB];
    end
    s3_neg_r <= l_neg;
    s3_mag_r <= tbt_pkg::MAG_W'(l_sum >> SH);
  end

  // Stage 4: scale by 29815*ln2.
  tbt_pkg::side_t s4_side_r;
  logic s4_neg_r;
  logic [38:0] s4_term_r;
  logic [tbt_pkg::MAG_W+31:0] prod_k;

  assign prod_k = s3_mag_r * tbt_pkg::KQ16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r <= '0;
    end else begin
      s4_side_r <= s3_side_r;
    end
    s4_neg_r  <= s3_neg_r;
    s4_term_r <= 39'(prod_k >> 16);
  end

  // Stage 5: denominator D and the scaled numerator product.
  tbt_pkg::side_t s5_side_r, s5_side_nxt;
  logic [DW-1:0] s5_d_r;
  logic [35:0] s5_nb_r;
  logic [40:0] base, dsum;

  always_comb begin
    base = {4'b0, 21'(beta_r) * 21'(tbt_pkg::BETA_SCALE), 16'b0};
    dsum = s4_neg_r ? base - {2'b0, s4_term_r} : base + {2'b0, s4_term_r};
    s5_side_nxt = s4_side_r;
    // A non-positive reciprocal temperature clamps to the top.
    if (s4_side_r.status == tbt_pkg::ST_OK && (dsum[40] || dsum == '0)) begin
      s5_side_nxt.status = tbt_pkg::ST_CLAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_side_r <= '0;
    end else begin
      s5_side_r <= s5_side_nxt;
    end
    s5_d_r  <= dsum[DW-1:0];
    s5_nb_r <= 36'(beta_r) * 36'(tbt_pkg::BETA_T0_SCALE);
  end

  // Stage 6: dividend with half of D added for rounding, and overflow check.
  tbt_pkg::side_t s6_side_r, s6_side_nxt;
  logic [DW-1:0] s6_rem_r, s6_d_r;
  logic [QW-1:0] s6_xlo_r;
  logic [tbt_pkg::X_W-1:0] xv;

  always_comb begin
    xv = {1'b0, s5_nb_r, 16'b0} + {15'b0, s5_d_r[DW-1:1]};
    s6_side_nxt = s5_side_r;
    // A quotient of 2^17 or more is far above the output range.
    if (s5_side_r.status == tbt_pkg::ST_OK &&
        {3'b0, xv[tbt_pkg::X_W-1:QW]} >= s5_d_r) begin
      s6_side_nxt.status = tbt_pkg::ST_CLAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_side_r <= '0;
    end else begin
      s6_side_r <= s6_side_nxt;
    end
    s6_rem_r <= {3'b0, xv[tbt_pkg::X_W-1:QW]};
    s6_d_r   <= s5_d_r;
    s6_xlo_r <= xv[QW-1:0];
  end

  // Division chain: cell j resolves quotient bit QW-1-j.
  tbt_pkg::side_t dside [0:QW];
  logic [DW-1:0] drem [0:QW];
  logic [DW-1:0] dd   [0:QW];
  logic [QW-1:0] dxlo [0:QW];
  logic [QW-1:0] dq   [0:QW];

  assign dside[0] = s6_side_r;
  assign drem[0]  = s6_rem_r;
  assign dd[0]    = s6_d_r;
  assign dxlo[0]  = s6_xlo_r;
  assign dq[0]    = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    tbt_div_cell #(.BIT(QW - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (dside[j]),
      .rem_i  (drem[j]),
      .d_i    (dd[j]),
      .xlo_i  (dxlo[j]),
      .q_i    (dq[j]),
      .side_o (dside[j+1]),
      .rem_o  (drem[j+1]),
      .d_o    (dd[j+1]),
      .xlo_o  (dxlo[j+1]),
      .q_o    (dq[j+1])
    );
  end

  // Output stage: kelvin to Celsius, saturation and special cases.
  logic out_valid_r;
  logic [15:0] temp_r, temp_nxt;
  tbt_pkg::status_t status_r, status_nxt;
  logic [17:0] celsius;

  always_comb begin
    celsius    = {1'b0, dq[QW]} - tbt_pkg::ZERO_C_CENTI;
    status_nxt = dside[QW].status;
    temp_nxt   = celsius[15:0];
    case (dside[QW].status)
      tbt_pkg::ST_OK: begin
        if (dq[QW] > tbt_pkg::TK_MAX) begin
          status_nxt = tbt_pkg::ST_CLAMP;
          temp_nxt   = tbt_pkg::TEMP_MAX;
        end
      end
      tbt_pkg::ST_HIGH: temp_nxt = tbt_pkg::TEMP_MIN;
      default:          temp_nxt = tbt_pkg::TEMP_MAX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dside[QW].valid;
    end
    temp_r   <= temp_nxt;
    status_r <= status_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_status            = status_r;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_side_r.valid)
    else $error("accepted item did not enter the pipeline");
  a_high_is_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tbt_pkg::ST_HIGH |-> out_temperature_centi == -16'sd32768)
    else $error("supply-side status without minimum temperature");
  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tbt_pkg::ST_ZERO || out_status == tbt_pkg::ST_CLAMP)
    |-> out_temperature_centi == 16'sd32767)
    else $error("saturating status without maximum temperature");
  a_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");
`endif
endmodule
`default_nettype wire
